### design/sorted_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue unit - assertion macros
// Shared assertion helpers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, register indexes, field widths and defaults.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PAYLOAD_BITS_DEF  = 32;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int OP_BITS        = 2;
  localparam int COUNT_BITS     = 5;
  localparam int REG_IDX_BITS   = 2;
  localparam int MAX_PRIO_RESET = 255;

  localparam logic [OP_BITS-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP_HEAD = 2'd1;
  localparam logic [OP_BITS-1:0] OP_POP_EQ   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_POP_GE   = 2'd3;

  localparam logic [REG_IDX_BITS-1:0] REG_MIN_PRIO = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_PRIO = 2'd1;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic push;   // insert the new item after all entries of equal or higher priority
    logic pop;    // a removal has a match this cycle
    logic exact;  // removal point is the first entry equal to the request
  } spq_cmd_t;

endpackage

### design/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready interfaces for the request, result and register write channels.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [OP_BITS-1:0]       operation;
  logic [PRIORITY_BITS-1:0] priority_req;
  logic [PAYLOAD_BITS-1:0]  payload;

  modport source (output valid, operation, priority_req, payload, input ready);
  modport sink (input valid, operation, priority_req, payload, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic [COUNT_BITS-1:0]    entry_count;

  modport source (output valid, ok, out_priority, out_payload, entry_count, input ready);
  modport sink (input valid, ok, out_priority, out_payload, entry_count, output ready);
endinterface

interface spq_cfg_if
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_BITS-1:0]  index;
  logic [PRIORITY_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One queue slot; keeps, loads, or takes its left or right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_cmd_t                 cmd,
  input  logic [PRIORITY_BITS-1:0] req_prio,
  input  logic [PAYLOAD_BITS-1:0]  new_pay,
  input  logic                     left_ge,
  input  logic                     left_eq,
  input  logic                     left_valid,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [PAYLOAD_BITS-1:0]  left_pay,
  input  logic                     right_valid,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [PAYLOAD_BITS-1:0]  right_pay,
  output logic                     valid,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [PAYLOAD_BITS-1:0]  pay,
  output logic                     ge,
  output logic                     eq,
  output logic                     first_eq
);

  logic                     valid_r, valid_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_BITS-1:0]  pay_r, pay_nxt;
  logic                     shift_left;

  assign ge       = valid_r && (prio_r >= req_prio);
  assign eq       = valid_r && (prio_r == req_prio);
  assign first_eq = eq && !left_eq;

  // Entries above the request priority stay put on an exact removal.
  assign shift_left = cmd.pop && (!cmd.exact || !(valid_r && (prio_r > req_prio)));

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    pay_nxt   = pay_r;
    if (cmd.push && !ge) begin
      if (left_ge) begin
        valid_nxt = 1'b1;
        prio_nxt  = req_prio;
        pay_nxt   = new_pay;
      end else begin
        valid_nxt = left_valid;
        prio_nxt  = left_prio;
        pay_nxt   = left_pay;
      end
    end else if (shift_left) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      pay_nxt   = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    pay_r  <= pay_nxt;
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign pay   = pay_r;

endmodule

### design/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue sorted by descending priority, FIFO among equal priorities.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake                    Carries
//   in_ch     in   valid/ready                  operation, priority_req, payload
//   out_ch    out  valid/ready                  ok, out_priority, out_payload, entry_count
//   cfg_ch    in   valid/ready (ready=1 out of reset) index, data (min/max push priority)
//
// One item per cycle unless out_ch stalls: the cell row settles an item in the
// cycle it is taken and the result sits in the output register from the next cycle on.
// The output register is the only stage; a new item is taken whenever it is
// empty or is being drained in the same cycle, so a stalled result blocks input.
// Synchronous active-low reset empties the queue and sets the bounds to the
// full range up to 8 priority bits; entry contents are not cleared, only valid bits.
// Hold both input channels not ready while reset is asserted.
//
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input logic  clk,
  input logic  rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch,
  spq_cfg_if.sink  cfg_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Bound registers
  logic [PRIORITY_BITS-1:0] min_prio_r, max_prio_r;

  // Cell row
  spq_cmd_t                 cmd;
  logic [CAPACITY-1:0]      cell_valid, cell_ge, cell_eq, cell_first_eq;
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  cell_pay  [CAPACITY];

  // Control
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     in_fire, full, in_bounds, push_ok, found, op_ok;
  logic [PRIORITY_BITS-1:0] eq_prio, rm_prio;
  logic [PAYLOAD_BITS-1:0]  eq_pay, rm_pay;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r;
  logic [PRIORITY_BITS-1:0] out_prio_r;
  logic [PAYLOAD_BITS-1:0]  out_pay_r;
  logic [COUNT_BITS-1:0]    out_count_r;
  logic [CNT_W+COUNT_BITS-1:0] count_ext;
  logic [CNT_W+COUNT_BITS-1:0] count_nxt_ext;

  // Checks
  logic [CAPACITY-1:0]      order_ok;
  logic [CAPACITY-1:0]      valid_plus1;

  // --------------------------------------------------------------------------
  // Register writes: ready out of reset, out-of-range indexes drop.
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_prio_r <= '0;
      max_prio_r <= PRIORITY_BITS'(MAX_PRIO_RESET);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIN_PRIO: min_prio_r <= cfg_ch.data;
        REG_MAX_PRIO: max_prio_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Decode the item and decide whether it changes the row.
  // --------------------------------------------------------------------------
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign full      = cell_valid[CAPACITY-1];
  assign in_bounds = (in_ch.priority_req >= min_prio_r) &&
                     (in_ch.priority_req <= max_prio_r);
  assign push_ok   = (in_ch.operation == OP_PUSH) && in_bounds && !full;

  // The sorted order puts every match of a head or at-least pop at the head;
  // exact matches form one run, whose first cell flags itself.
  always_comb begin
    case (in_ch.operation)
      OP_POP_HEAD: found = cell_valid[0];
      OP_POP_EQ:   found = |cell_first_eq;
      OP_POP_GE:   found = cell_ge[0];
      default:     found = 1'b0;
    endcase
  end

  assign cmd.push  = in_fire && push_ok;
  assign cmd.pop   = in_fire && found;
  assign cmd.exact = (in_ch.operation == OP_POP_EQ);

  // Pick the removed entry of an exact pop from the one-hot first match.
  always_comb begin
    eq_prio = '0;
    eq_pay  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      eq_prio = eq_prio | (cell_prio[i] & {PRIORITY_BITS{cell_first_eq[i]}});
      eq_pay  = eq_pay  | (cell_pay[i]  & {PAYLOAD_BITS{cell_first_eq[i]}});
    end
  end

  always_comb begin
    rm_prio = '0;
    rm_pay  = '0;
    if (found) begin
      if (cmd.exact) begin
        rm_prio = eq_prio;
        rm_pay  = eq_pay;
      end else begin
        rm_prio = cell_prio[0];
        rm_pay  = cell_pay[0];
      end
    end
  end

  assign op_ok = push_ok || found;

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the head; each cell sees only its neighbors and the broadcast request.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     l_ge, l_eq, l_valid, r_valid;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0]  l_pay, r_pay;

    if (g == 0) begin : g_head
      assign l_ge    = 1'b1;
      assign l_eq    = 1'b0;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_pay   = '0;
    end else begin : g_body
      assign l_ge    = cell_ge[g-1];
      assign l_eq    = cell_eq[g-1];
      assign l_valid = cell_valid[g-1];
      assign l_prio  = cell_prio[g-1];
      assign l_pay   = cell_pay[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_pay   = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[g+1];
      assign r_prio  = cell_prio[g+1];
      assign r_pay   = cell_pay[g+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .req_prio    (in_ch.priority_req),
      .new_pay     (in_ch.payload),
      .left_ge     (l_ge),
      .left_eq     (l_eq),
      .left_valid  (l_valid),
      .left_prio   (l_prio),
      .left_pay    (l_pay),
      .right_valid (r_valid),
      .right_prio  (r_prio),
      .right_pay   (r_pay),
      .valid       (cell_valid[g]),
      .prio        (cell_prio[g]),
      .pay         (cell_pay[g]),
      .ge          (cell_ge[g]),
      .eq          (cell_eq[g]),
      .first_eq    (cell_first_eq[g])
    );
  end

  // --------------------------------------------------------------------------
  // Entry count and result register.
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until taken; a new item only lands when the slot frees.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ok_r   <= op_ok;
      out_prio_r <= rm_prio;
      out_pay_r  <= rm_pay;
    end
  end

  assign count_ext = {{COUNT_BITS{1'b0}}, count_r};

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.out_payload  = out_pay_r;
  // Count sampled with the result: the register has advanced by this item only.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_count_r <= count_nxt_ext[COUNT_BITS-1:0];
    end
  end

  assign count_nxt_ext      = {{COUNT_BITS{1'b0}}, count_nxt};
  assign out_ch.entry_count = out_count_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  always_comb begin
    order_ok = '1;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      order_ok[i] = !cell_valid[i+1] || (cell_prio[i] >= cell_prio[i+1]);
    end
  end

  assign valid_plus1 = cell_valid + CAPACITY'(1);

  `SPQ_ASSERT_IMPLIES(a_count_tracks_cells, 1'b1, count_ext[CNT_W-1:0] == CNT_W'($countones(cell_valid)), "entry count disagrees with occupied cells")
  `SPQ_ASSERT_IMPLIES(a_cells_packed, 1'b1, (cell_valid & valid_plus1) == '0, "occupied cells are not packed at the head")
  `SPQ_ASSERT_IMPLIES(a_cells_sorted, 1'b1, &order_ok, "cell priorities not in descending order")
  `SPQ_ASSERT_IMPLIES(a_one_exact_match, 1'b1, $onehot0(cell_first_eq), "more than one exact-match start")
  `SPQ_ASSERT_NEXT(a_push_grows, cmd.push, count_r == $past(count_r) + 1'b1, "accepted push did not add an entry")

endmodule
